// File: sv/assert_macros.svh
// assertion macros shared by the crank detect and auto tare rtl
// every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define SCD_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/scd_pkg.sv
// shared types and constants for the crank detect and auto tare unit
// no dependencies
`default_nettype none

package scd_pkg;

    localparam int STORE_DEPTH  = 64;
    localparam int CRANK_MIN_MS = 100;

    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 32;
    localparam int IDX_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W      = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W     = IDX_W + 2;
    localparam int SUM_W      = SAMPLE_W + CNT_W + 1;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WIN_W      = 7;
    localparam int RANGE_W    = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_DELAY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_WIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_RANGE = 3'd7;

    // item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [1:0] {
        NEG_KEEP,
        NEG_CLAMP,
        NEG_DISCARD,
        NEG_ABS
    } neg_mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PREP,
        S_SCAN,
        S_LAST,
        S_DIVLD,
        S_DIV,
        S_FIN
    } scd_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic start;
        logic prep;
        logic scan;
        logic div_load;
        logic fin;
    } scd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_read;
        logic scan_go;
        logic scan_last;
        logic div_done;
        logic out_free;
    } scd_status_t;

endpackage

`default_nettype wire

// File: sv/scd_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module scd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/scd_div.sv
// restoring divider, one quotient bit per cycle, for the store average
// depends on scd_pkg
`default_nettype none

module scd_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [scd_pkg::SUM_W-1:0]  dividend,
    input  wire logic [scd_pkg::CNT_W-1:0]  divisor,
    output logic                            done,
    output logic      [scd_pkg::SUM_W-1:0]  quotient
);
    import scd_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     q_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W:0]       shifted;
    logic                 fits;

    // trial subtract of the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, q_reg[SUM_W-1]};
        fits    = shifted >= {1'b0, divisor};
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? CNT_W'(shifted - {1'b0, divisor}) : CNT_W'(shifted);
        end
    end

    assign done     = !busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: sv/scd_ctrl.sv
// controller state machine sequencing one item through the datapath
// depends on scd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module scd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire scd_pkg::scd_status_t status,
    output scd_pkg::scd_cmd_t         cmd
);
    import scd_pkg::*;

    scd_state_t state_reg;
    scd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START: state_next = S_PREP;
            S_PREP:  state_next = status.scan_go ? S_SCAN : S_FIN;
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:  state_next = status.op_read ? S_DIVLD : S_FIN;
            S_DIVLD: state_next = S_DIV;
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_START: cmd.start    = 1'b1;
            S_PREP:  cmd.prep     = 1'b1;
            S_SCAN:  cmd.scan     = 1'b1;
            S_DIVLD: cmd.div_load = 1'b1;
            S_FIN:   cmd.fin      = status.out_free;
            default: cmd          = '0;
        endcase
    end

    `SCD_ASSERT_NXT(a_capture_starts, cmd.capture, state_reg == S_START, "capture did not start")
    `SCD_ASSERT_NXT(a_fin_holds, state_reg == S_FIN && !status.out_free, state_reg == S_FIN,
        "result dropped while output busy")
    `SCD_ASSERT_IMP(a_scan_from_prep, cmd.scan, state_reg == S_SCAN, "scan outside scan state")

endmodule

`default_nettype wire

// File: sv/scd_dp.sv
// datapath: config, sample store, crank detector, tare scan, average
// depends on scd_pkg, scd_ram, scd_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module scd_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire scd_pkg::scd_cmd_t                 cmd,
    output scd_pkg::scd_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              opcode,
    input  wire logic signed [scd_pkg::SAMPLE_W-1:0] sample_grams,
    input  wire logic [scd_pkg::TIME_W-1:0]        time_ms,
    input  wire logic                              clear_store,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   crank_event,
    output logic [scd_pkg::TIME_W-1:0]             revolution_count,
    output logic [scd_pkg::TIME_W-1:0]             crank_interval_ms,
    output logic                                   tare_request,
    output logic signed [scd_pkg::SAMPLE_W-1:0]    average_grams,
    output logic                                   average_valid
);
    import scd_pkg::*;

    // configuration
    logic                       motion_en_reg;
    logic signed [SAMPLE_W-1:0] thr_high_reg;
    logic signed [SAMPLE_W-1:0] thr_low_reg;
    neg_mode_t                  neg_mode_reg;
    logic                       tare_en_reg;
    logic [TIME_W-1:0]          delay_reg;
    logic [WIN_W-1:0]           win_reg;
    logic [RANGE_W-1:0]         range_reg;

    // captured item
    logic                       op_reg;
    logic                       clr_reg;
    logic signed [SAMPLE_W-1:0] s_reg;
    logic [TIME_W-1:0]          t_reg;

    // persistent state
    logic [IDX_W-1:0]           head_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       armed_reg;
    logic [TIME_W-1:0]          lct_reg;
    logic [TIME_W-1:0]          rev_reg;
    logic [TIME_W-1:0]          ltt_reg;

    // per item work
    logic                       ev_reg;
    logic [TIME_W-1:0]          intv_reg;
    logic                       tare_pend_reg;
    logic                       avg_valid_reg;
    logic [CNT_W-1:0]           len_reg;
    logic [CNT_W-1:0]           k_reg;
    logic                       rd_pend_reg;
    logic                       first_reg;
    logic signed [SAMPLE_W-1:0] mn_reg;
    logic signed [SAMPLE_W-1:0] mx_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]           n_reg;

    // output register
    logic                       out_valid_reg;
    logic                       ev_out_reg;
    logic [TIME_W-1:0]          rev_out_reg;
    logic [TIME_W-1:0]          intv_out_reg;
    logic                       tare_out_reg;
    logic signed [SAMPLE_W-1:0] avg_out_reg;
    logic                       avg_valid_out_reg;

    // combinational
    logic [TIME_W-1:0]          dt;
    logic [TIME_W-1:0]          cutoff;
    logic                       tare_cond;
    logic [CNT_W-1:0]           win_len;
    logic [ADDR_W-1:0]          addr_raw;
    logic [IDX_W-1:0]           head_inc;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_v;
    logic signed [SAMPLE_W:0]   term;
    logic                       take;
    logic                       sum_neg;
    logic [SUM_W-1:0]           sum_mag;
    logic                       div_done;
    logic [SUM_W-1:0]           quot;
    logic signed [SAMPLE_W-1:0] avg_res;
    logic signed [SAMPLE_W:0]   spread;
    logic                       tare_res;
    logic                       out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_en_reg <= 1'b1;
            thr_high_reg  <= '0;
            thr_low_reg   <= '0;
            neg_mode_reg  <= NEG_KEEP;
            tare_en_reg   <= 1'b0;
            delay_reg     <= '0;
            win_reg       <= '0;
            range_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOTION_EN:  motion_en_reg <= cfg_data[0];
                CFG_THR_HIGH:   thr_high_reg  <= $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_THR_LOW:    thr_low_reg   <= $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_NEG_MODE:   neg_mode_reg  <= neg_mode_t'(cfg_data[1:0]);
                CFG_TARE_EN:    tare_en_reg   <= cfg_data[0];
                CFG_TARE_DELAY: delay_reg     <= cfg_data[TIME_W-1:0];
                CFG_TARE_WIN:   win_reg       <= cfg_data[WIN_W-1:0];
                CFG_TARE_RANGE: range_reg     <= cfg_data[RANGE_W-1:0];
                default:        motion_en_reg <= motion_en_reg;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            clr_reg <= clear_store;
            s_reg   <= sample_grams;
            t_reg   <= time_ms;
        end
    end

    // crank timing and tare gating
    always_comb
    begin
        dt        = t_reg - lct_reg;
        cutoff    = t_reg - delay_reg;
        tare_cond = tare_en_reg && (delay_reg < t_reg) && (lct_reg < cutoff)
                    && (ltt_reg < cutoff);
        win_len   = (32'(win_reg) > 32'(count_reg)) ? count_reg : CNT_W'(win_reg);
        head_inc  = (head_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    end

    // store read address: newest first for tare, oldest first for read
    always_comb
    begin
        if (op_reg == OP_READ)
        begin
            addr_raw = ADDR_W'(head_reg) + ADDR_W'(STORE_DEPTH) - ADDR_W'(count_reg)
                       + ADDR_W'(k_reg);
        end
        else
        begin
            addr_raw = ADDR_W'(head_reg) + ADDR_W'(STORE_DEPTH) - ADDR_W'(1)
                       - ADDR_W'(k_reg);
        end
        ram_raddr = (addr_raw >= ADDR_W'(STORE_DEPTH)) ?
                    IDX_W'(addr_raw - ADDR_W'(STORE_DEPTH)) : IDX_W'(addr_raw);
        ram_we    = cmd.start && (op_reg == OP_SAMPLE);
    end

    scd_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(head_reg),
        .wdata(s_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // negative mode term for the average
    always_comb
    begin
        rd_v = $signed(ram_rdata);
        term = (SAMPLE_W + 1)'(rd_v);
        take = 1'b1;
        case (neg_mode_reg)
            NEG_KEEP:    term = (SAMPLE_W + 1)'(rd_v);
            NEG_CLAMP:   term = rd_v[SAMPLE_W-1] ? '0 : (SAMPLE_W + 1)'(rd_v);
            NEG_DISCARD: take = !rd_v[SAMPLE_W-1];
            NEG_ABS:     term = rd_v[SAMPLE_W-1] ? -(SAMPLE_W + 1)'(rd_v)
                                                 : (SAMPLE_W + 1)'(rd_v);
            default:     term = (SAMPLE_W + 1)'(rd_v);
        endcase
    end

    // store pointers and crank detector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            armed_reg <= 1'b0;
            lct_reg   <= '0;
            rev_reg   <= '0;
            ltt_reg   <= '0;
            ev_reg    <= 1'b0;
            intv_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                ev_reg   <= 1'b0;
                intv_reg <= '0;
            end
            if (cmd.start && op_reg == OP_SAMPLE)
            begin
                head_reg <= head_inc;
                if (count_reg < CNT_W'(STORE_DEPTH))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (motion_en_reg)
                begin
                    if (!armed_reg)
                    begin
                        if (s_reg <= thr_low_reg)
                        begin
                            armed_reg <= 1'b1;
                        end
                    end
                    else if (thr_high_reg <= s_reg)
                    begin
                        armed_reg <= 1'b0;
                        if (lct_reg != '0)
                        begin
                            if (TIME_W'(CRANK_MIN_MS) < dt)
                            begin
                                rev_reg  <= rev_reg + TIME_W'(1);
                                lct_reg  <= t_reg;
                                ev_reg   <= 1'b1;
                                intv_reg <= dt;
                            end
                        end
                        else
                        begin
                            lct_reg <= t_reg;
                        end
                    end
                end
            end
            if (cmd.prep && op_reg == OP_SAMPLE && tare_cond)
            begin
                ltt_reg <= t_reg;
            end
            if (cmd.fin && op_reg == OP_READ && clr_reg)
            begin
                head_reg  <= '0;
                count_reg <= '0;
            end
        end
    end

    // scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            tare_pend_reg <= 1'b0;
            avg_valid_reg <= 1'b0;
            k_reg         <= '0;
            len_reg       <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan;
            if (cmd.prep)
            begin
                k_reg         <= '0;
                len_reg       <= (op_reg == OP_READ) ? count_reg : win_len;
                tare_pend_reg <= (op_reg == OP_SAMPLE) && status.scan_go;
                avg_valid_reg <= (op_reg == OP_READ) && status.scan_go;
            end
            else if (cmd.scan)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
        end
    end

    // min, max and sum accumulation on returned data
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            first_reg <= 1'b1;
            mn_reg    <= '0;
            mx_reg    <= '0;
            sum_reg   <= '0;
            n_reg     <= '0;
        end
        else if (rd_pend_reg)
        begin
            if (op_reg == OP_READ)
            begin
                if (take)
                begin
                    sum_reg <= sum_reg + SUM_W'(term);
                    n_reg   <= n_reg + CNT_W'(1);
                end
            end
            else
            begin
                first_reg <= 1'b0;
                if (first_reg || rd_v < mn_reg)
                begin
                    mn_reg <= rd_v;
                end
                if (first_reg || rd_v > mx_reg)
                begin
                    mx_reg <= rd_v;
                end
            end
        end
    end

    // magnitude division of the sum
    always_comb
    begin
        sum_neg = sum_reg[SUM_W-1];
        sum_mag = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    end

    scd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_load),
        .dividend(sum_mag),
        .divisor (n_reg),
        .done    (div_done),
        .quotient(quot)
    );

    // signed average with saturation, tare spread check
    always_comb
    begin
        if (!avg_valid_reg || n_reg == '0)
        begin
            avg_res = '0;
        end
        else if (sum_neg)
        begin
            avg_res = (quot >= SUM_W'(2 ** (SAMPLE_W - 1))) ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                                                              : -$signed(quot[SAMPLE_W-1:0]);
        end
        else
        begin
            avg_res = (quot > SUM_W'(2 ** (SAMPLE_W - 1) - 1)) ?
                      {1'b0, {(SAMPLE_W - 1){1'b1}}} : $signed(quot[SAMPLE_W-1:0]);
        end
        spread   = (SAMPLE_W + 1)'(mx_reg) - (SAMPLE_W + 1)'(mn_reg);
        tare_res = tare_pend_reg
                   && (spread < $signed({{(SAMPLE_W + 1 - RANGE_W){1'b0}}, range_reg}));
        out_free = !out_valid_reg || out_ready;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            rev_out_reg <= rev_reg;
            if (op_reg == OP_READ)
            begin
                ev_out_reg        <= 1'b0;
                intv_out_reg      <= '0;
                tare_out_reg      <= 1'b0;
                avg_out_reg       <= avg_res;
                avg_valid_out_reg <= avg_valid_reg;
            end
            else
            begin
                ev_out_reg        <= ev_reg;
                intv_out_reg      <= intv_reg;
                tare_out_reg      <= tare_res;
                avg_out_reg       <= '0;
                avg_valid_out_reg <= 1'b0;
            end
        end
    end

    // status back to the controller
    always_comb
    begin
        status.op_read   = (op_reg == OP_READ);
        status.scan_go   = (op_reg == OP_READ) ? (count_reg != '0)
                                               : (tare_cond && win_len != '0);
        status.scan_last = (k_reg == len_reg - CNT_W'(1));
        status.div_done  = div_done;
        status.out_free  = out_free;
    end

    assign out_valid         = out_valid_reg;
    assign crank_event       = ev_out_reg;
    assign revolution_count  = rev_out_reg;
    assign crank_interval_ms = intv_out_reg;
    assign tare_request      = tare_out_reg;
    assign average_grams     = avg_out_reg;
    assign average_valid     = avg_valid_out_reg;

    `SCD_ASSERT(a_count_bound, count_reg <= CNT_W'(STORE_DEPTH), "store count above depth")
    `SCD_ASSERT_IMP(a_head_tracks, count_reg < CNT_W'(STORE_DEPTH),
        CNT_W'(head_reg) == count_reg, "head out of step with count before full")
    `SCD_ASSERT_NXT(a_fin_loads, cmd.fin, out_valid_reg, "finished item not presented")

endmodule

`default_nettype wire

// File: sv/strain_crank_detect_autotare_unit.sv
// Crank detect and auto tare unit: sample store, hysteresis detector, tare scan, average.
// One item at a time. Sample op: store write and crank detect, plus a tare window scan when it runs.
// Read op: store scan of one ram read a cycle, then a one bit per cycle divider.
// An output register lets the next item in while a result waits.
// Reset (rst_n, async, active low) clears config to defaults and the store to empty.
// depends on scd_pkg, scd_ctrl, scd_dp
`default_nettype none

module strain_crank_detect_autotare_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [scd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [scd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                opcode,
    input  wire logic signed [scd_pkg::SAMPLE_W-1:0] sample_grams,
    input  wire logic [scd_pkg::TIME_W-1:0]          time_ms,
    input  wire logic                                clear_store,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     crank_event,
    output logic [scd_pkg::TIME_W-1:0]               revolution_count,
    output logic [scd_pkg::TIME_W-1:0]               crank_interval_ms,
    output logic                                     tare_request,
    output logic signed [scd_pkg::SAMPLE_W-1:0]      average_grams,
    output logic                                     average_valid
);
    import scd_pkg::*;

    scd_cmd_t    cmd;
    scd_status_t status;

    scd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    scd_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .opcode           (opcode),
        .sample_grams     (sample_grams),
        .time_ms          (time_ms),
        .clear_store      (clear_store),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .crank_event      (crank_event),
        .revolution_count (revolution_count),
        .crank_interval_ms(crank_interval_ms),
        .tare_request     (tare_request),
        .average_grams    (average_grams),
        .average_valid    (average_valid)
    );

endmodule

`default_nettype wire

// File: sim/strain_crank_detect_autotare_unit_test.sv
// self-checking testbench for strain_crank_detect_autotare_unit: random and directed items
// with a cycle-free predictor of detection, auto tare and averaging; depends on scd_pkg
`timescale 1ns / 1ps

module strain_crank_detect_autotare_unit_test;
    import scd_pkg::*;

    typedef struct {
        logic             op;
        logic signed [23:0] grams;
        logic [31:0]      tms;
        logic             clr;
    } item_t;

    typedef struct {
        logic             ev;
        logic [31:0]      revs;
        logic [31:0]      interval;
        logic             tare;
        logic signed [23:0] avg;
        logic             avg_ok;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    wire  in_ready;
    logic opcode;
    logic signed [23:0] sample_grams;
    logic [31:0] time_ms;
    logic clear_store;
    wire  out_valid;
    logic out_ready;
    wire  crank_event;
    wire  [31:0] revolution_count;
    wire  [31:0] crank_interval_ms;
    wire  tare_request;
    wire  signed [23:0] average_grams;
    wire  average_valid;

    strain_crank_detect_autotare_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .sample_grams(sample_grams), .time_ms(time_ms),
        .clear_store(clear_store), .out_valid(out_valid), .out_ready(out_ready),
        .crank_event(crank_event), .revolution_count(revolution_count),
        .crank_interval_ms(crank_interval_ms), .tare_request(tare_request),
        .average_grams(average_grams), .average_valid(average_valid)
    );

    // predictor copy of the configuration
    logic        m_motion_en;
    logic signed [23:0] m_thr_hi;
    logic signed [23:0] m_thr_lo;
    neg_mode_t   m_neg;
    logic        m_tare_en;
    logic [31:0] m_tare_delay;
    logic [6:0]  m_tare_win;
    logic [15:0] m_tare_range;

    // predictor copy of the state
    logic signed [23:0] m_store [STORE_DEPTH];
    int          m_count;
    int          m_head;
    logic        m_armed;
    logic [31:0] m_last_crank;
    logic [31:0] m_revs;
    logic [31:0] m_last_tare;

    item_t    pending_items[$];
    outcome_t expected_outcomes[$];
    int mismatches;
    int n_sent;
    int n_checked;
    int n_events;
    int n_tares;
    int n_reads;
    bit stall_hold;
    bit stim_done;
    logic [31:0] now_ms;

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // register write on both the block and the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            CFG_MOTION_EN:  m_motion_en = val[0];
            CFG_THR_HIGH:   m_thr_hi = val[23:0];
            CFG_THR_LOW:    m_thr_lo = val[23:0];
            CFG_NEG_MODE:   m_neg = neg_mode_t'(val[1:0]);
            CFG_TARE_EN:    m_tare_en = val[0];
            CFG_TARE_DELAY: m_tare_delay = val;
            CFG_TARE_WIN:   m_tare_win = val[6:0];
            default:        m_tare_range = val[15:0];
        endcase
    endtask

    // compute the result of one item and advance predicted state
    function automatic outcome_t predict_step(input item_t it);
        outcome_t r;
        logic [31:0] dt;
        logic [31:0] cutoff;
        longint sum;
        longint n;
        longint v;
        longint mn;
        longint mx;
        longint avg;
        int w;
        r = '{default: 0};
        if (it.op == OP_SAMPLE) begin
            m_store[m_head] = it.grams;
            m_head = (m_head + 1) % STORE_DEPTH;
            if (m_count < STORE_DEPTH) m_count++;
            if (m_motion_en) begin
                if (!m_armed) begin
                    if (it.grams <= m_thr_lo) m_armed = 1;
                end else if (m_thr_hi <= it.grams) begin
                    m_armed = 0;
                    if (m_last_crank != 0) begin
                        dt = it.tms - m_last_crank;
                        if (dt > CRANK_MIN_MS) begin
                            m_revs++;
                            m_last_crank = it.tms;
                            r.ev = 1;
                            r.interval = dt;
                        end
                    end else begin
                        m_last_crank = it.tms;
                    end
                end
            end
            if (m_tare_en && m_tare_delay < it.tms) begin
                cutoff = it.tms - m_tare_delay;
                if (m_last_crank < cutoff && m_last_tare < cutoff && m_count > 0) begin
                    w = (m_tare_win > m_count) ? m_count : m_tare_win;
                    mn = 0;
                    mx = 0;
                    for (int k = 0; k < w; k++) begin
                        v = m_store[(m_head + STORE_DEPTH - 1 - k) % STORE_DEPTH];
                        if (k == 0 || v < mn) mn = v;
                        if (k == 0 || v > mx) mx = v;
                    end
                    m_last_tare = it.tms;
                    if (w > 0 && mx - mn < longint'(m_tare_range)) r.tare = 1;
                end
            end
        end else begin
            if (m_count > 0) begin
                sum = 0;
                n = 0;
                avg = 0;
                r.avg_ok = 1;
                for (int i = 0; i < m_count; i++) begin
                    v = m_store[(m_head + STORE_DEPTH - m_count + i) % STORE_DEPTH];
                    case (m_neg)
                        NEG_KEEP:    begin sum += v; n++; end
                        NEG_CLAMP:   begin sum += (v < 0) ? 0 : v; n++; end
                        NEG_DISCARD: if (v >= 0) begin sum += v; n++; end
                        default:     begin sum += (v < 0) ? -v : v; n++; end
                    endcase
                end
                if (n > 0) avg = sum / n;
                if (avg > 8388607) avg = 8388607;
                if (avg < -8388608) avg = -8388608;
                r.avg = avg[23:0];
            end
            if (it.clr) begin
                m_count = 0;
                m_head = 0;
            end
        end
        r.revs = m_revs;
        return r;
    endfunction

    function automatic item_t make_sample(input logic signed [23:0] g, input logic [31:0] t);
        item_t it;
        it.op = OP_SAMPLE;
        it.grams = g;
        it.tms = t;
        it.clr = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic item_t make_read(input logic clr);
        item_t it;
        it.op = OP_READ;
        it.grams = $urandom;
        it.tms = $urandom;
        it.clr = clr;
        return it;
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (in_valid && !in_ready) begin
            // hold item
        end else begin
            if (in_valid) begin
                expected_outcomes.push_back(predict_step(pending_items.pop_front()));
                n_sent++;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 0;
            end else if (pending_items.size() > 0) begin
                // front of the queue is the next item to offer
                in_valid <= 1;
                opcode <= pending_items[0].op;
                sample_grams <= pending_items[0].grams;
                time_ms <= pending_items[0].tms;
                clear_store <= pending_items[0].clr;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 0;
            end
        end
    end

    // receiver: stalls on its own pattern, plus one long counted hold-off when asked
    int stall_phase;
    int hold_left;
    bit hold_done;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 0;
            stall_phase <= 0;
            hold_left <= 0;
            hold_done <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_hold && !hold_done) begin
                hold_left <= 3000;
                hold_done <= 1;
                out_ready <= 0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 0;
            end else if (stall_phase[9:8] == 2'b00)
                out_ready <= 1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result with no item pending");
            end else begin
                outcome_t e;
                e = expected_outcomes.pop_front();
                n_checked++;
                if (e.ev) n_events++;
                if (e.tare) n_tares++;
                if (e.avg_ok) n_reads++;
                if (crank_event !== e.ev || revolution_count !== e.revs
                    || crank_interval_ms !== e.interval || tare_request !== e.tare
                    || average_grams !== e.avg || average_valid !== e.avg_ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ev=%0d rev=%0d int=%0d tare=%0d avg=%0d v=%0d",
                                 e.ev, e.revs, e.interval, e.tare, e.avg, e.avg_ok,
                                 " got ev=%0d rev=%0d int=%0d tare=%0d avg=%0d v=%0d",
                                 crank_event, revolution_count, crank_interval_ms,
                                 tare_request, average_grams, average_valid);
                end
            end
        end
    end

    // wait until everything queued has been checked, then let the block settle
    task automatic drain;
        while (pending_items.size() > 0 || in_valid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // a crank-like waveform with random content and some noise
    task automatic queue_phase(input int n_items);
        logic signed [23:0] g;
        for (int i = 0; i < n_items; i++) begin
            now_ms = now_ms + $urandom_range(0, 80);
            case ($urandom_range(0, 9))
                0: pending_items.push_back(make_read($urandom_range(0, 3) == 0));
                1: pending_items.push_back(make_sample($urandom, $urandom));
                2: pending_items.push_back(make_sample(
                       $urandom_range(0, 1) ? 24'sh7fffff : -24'sh800000, now_ms));
                default: begin
                    g = (i % 6 < 3) ? m_thr_lo - $signed({1'b0, 8'($urandom)})
                                    : m_thr_hi + $signed({1'b0, 8'($urandom)});
                    if ($urandom_range(0, 3) == 0) g = $urandom_range(0, 60);
                    pending_items.push_back(make_sample(g, now_ms));
                end
            endcase
        end
    endtask

    initial begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_MOTION_EN;
        cfg_data = 0;
        opcode = OP_SAMPLE;
        sample_grams = 0;
        time_ms = 0;
        clear_store = 0;
        stall_hold = 0;
        stim_done = 0;
        mismatches = 0;
        n_sent = 0;
        n_checked = 0;
        n_events = 0;
        n_tares = 0;
        n_reads = 0;
        now_ms = 1000;
        m_motion_en = 1;
        m_thr_hi = 0;
        m_thr_lo = 0;
        m_neg = NEG_KEEP;
        m_tare_en = 0;
        m_tare_delay = 0;
        m_tare_win = 0;
        m_tare_range = 0;
        m_count = 0;
        m_head = 0;
        m_armed = 0;
        m_last_crank = 0;
        m_revs = 0;
        m_last_tare = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // directed: reads on empty store, extremes, first fire, time wrap, all discarded
        pending_items.push_back(make_read(0));
        pending_items.push_back(make_sample(-24'sh800000, 32'd0));
        pending_items.push_back(make_sample(24'sh7fffff, 32'd50));
        pending_items.push_back(make_sample(-24'sh000010, 32'd120));
        pending_items.push_back(make_sample(24'sh000010, 32'd200));
        pending_items.push_back(make_sample(-24'sh000010, 32'd260));
        pending_items.push_back(make_sample(24'sh000010, 32'd290));
        pending_items.push_back(make_sample(-24'sh000010, 32'hffffffc0));
        pending_items.push_back(make_sample(24'sh000010, 32'h00000040));
        pending_items.push_back(make_read(0));
        pending_items.push_back(make_read(1));
        pending_items.push_back(make_read(1));
        drain();
        write_reg(CFG_NEG_MODE, NEG_DISCARD);
        for (int i = 0; i < 3; i++)
            pending_items.push_back(make_sample(-24'sh800000, 32'd400 + i));
        pending_items.push_back(make_read(0));
        drain();
        write_reg(CFG_NEG_MODE, NEG_ABS);
        pending_items.push_back(make_read(0));
        pending_items.push_back(make_read(1));
        drain();

        // random phases through several settings, extremes included
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_MOTION_EN, (ph % 5) != 4);
            write_reg(CFG_THR_HIGH, (ph == 3) ? 32'h007fffff : $urandom_range(100, 3000));
            write_reg(CFG_THR_LOW, (ph == 3) ? 32'h00800000 : -$urandom_range(0, 3000));
            write_reg(CFG_NEG_MODE, ph % 4);
            write_reg(CFG_TARE_EN, ph % 3 != 2);
            write_reg(CFG_TARE_DELAY, (ph == 5) ? 32'hffffffff : $urandom_range(0, 600));
            write_reg(CFG_TARE_WIN, (ph == 6) ? 64 : (ph == 7) ? 0 : $urandom_range(1, 64));
            write_reg(CFG_TARE_RANGE, (ph == 8) ? 32'hffff : $urandom_range(0, 5000));
            // the receiver holds off for a long stretch while the items pile up
            if (ph == 4)
                stall_hold = 1;
            queue_phase(150);
            drain();
        end
        stim_done = 1;

        $display("sent %0d items, checked %0d results", n_sent, n_checked);
        $display("crank events %0d, tare requests %0d, valid averages %0d",
                 n_events, n_tares, n_reads);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("strain_crank_detect_autotare_unit test passed");
        else
            $display("strain_crank_detect_autotare_unit test failed");
        $finish;
    end

    // timeout guard
    initial begin
        #8ms;
        $display("strain_crank_detect_autotare_unit test failed");
        $finish;
    end

endmodule
